@@ rtl/core/tds_pkg.sv @@
package tds_pkg;

    localparam int MAX_SIZE = 64;
    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int CNT_W    = $clog2(MAX_SIZE + 1);
    localparam int DATA_W   = 48;
    localparam int CFG_W    = 47;
    localparam int CIDX_W   = 3;
    localparam int SWP_W    = 16;

    localparam logic [DATA_W-1:0] Q_ONE   = 48'h0001_0000_0000;
    localparam logic [DATA_W-1:0] POS_LIM = 48'h7FFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_LIM = 48'h8000_0000_0000;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ALPHA     = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_OMEGA     = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_TOLERANCE = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_MAX_SWEEP = 3'd3;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_MA,
        ST_WA,
        ST_MB,
        ST_WB,
        ST_DG,
        ST_WD,
        ST_MC,
        ST_WC,
        ST_MD,
        ST_WM,
        ST_WR,
        ST_ACC,
        ST_CHK,
        ST_ORD,
        ST_OCAP,
        ST_OSEND
    } state_t;

    // magnitude of a signed word; the most negative value maps to 2^47
    function automatic logic [DATA_W-1:0] mag48(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r = v[DATA_W-1] ? (DATA_W'(0) - DATA_W'(v)) : DATA_W'(v);
        return r;
    endfunction

    // clamp a widened signed sum into the signed 48-bit range
    function automatic logic signed [DATA_W-1:0] sat48(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > $signed({2'b00, POS_LIM}))
        begin
            r = $signed(POS_LIM);
        end
        else if (v < $signed({2'b11, NEG_LIM}))
        begin
            r = $signed(NEG_LIM);
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/tds_ram.sv @@
module tds_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/tds_mul.sv @@
module tds_mul (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [tds_pkg::DATA_W-1:0]    a,
    input  logic signed [tds_pkg::DATA_W-1:0]    b,
    output logic                                 done,
    output logic signed [tds_pkg::DATA_W-1:0]    result
);

    localparam int HW = tds_pkg::DATA_W / 2;
    localparam int PW = 2 * tds_pkg::DATA_W;

    logic                        busy_reg;
    logic [2:0]                  step_reg;
    logic [tds_pkg::DATA_W-1:0]  ma_reg;
    logic [tds_pkg::DATA_W-1:0]  mb_reg;
    logic                        neg_reg;
    logic [2*HW-1:0]             pp_reg;
    logic [1:0]                  sh_reg;
    logic [PW-1:0]               acc_reg;
    logic                        done_reg;
    logic signed [tds_pkg::DATA_W-1:0] res_reg;

    logic [HW-1:0]               a_chunk;
    logic [HW-1:0]               b_chunk;
    logic [PW-1:0]               pp_shift;
    logic [64:0]                 rnd;
    logic [tds_pkg::DATA_W-1:0]  lim;
    logic [tds_pkg::DATA_W-1:0]  sat_mag;

    // pick 24-bit chunks of the magnitudes
    always_comb
    begin
        a_chunk = step_reg[0] ? ma_reg[2*HW-1:HW] : ma_reg[HW-1:0];
        b_chunk = step_reg[1] ? mb_reg[2*HW-1:HW] : mb_reg[HW-1:0];
        case (sh_reg)
            2'd0:    pp_shift = {{(PW-2*HW){1'b0}}, pp_reg};
            2'd1:    pp_shift = {{(PW-2*HW){1'b0}}, pp_reg} << HW;
            default: pp_shift = {{(PW-2*HW){1'b0}}, pp_reg} << (2 * HW);
        endcase
    end

    // round half up at bit 31, then clamp the magnitude
    always_comb
    begin
        rnd = {1'b0, acc_reg[PW-1:32]} + 65'(acc_reg[31]);
        lim = neg_reg ? tds_pkg::NEG_LIM : tds_pkg::POS_LIM;
        sat_mag = (rnd > {17'b0, lim}) ? lim : rnd[tds_pkg::DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // partial products, accumulation and final result
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= tds_pkg::mag48(a);
            mb_reg  <= tds_pkg::mag48(b);
            neg_reg <= (a[tds_pkg::DATA_W-1] != b[tds_pkg::DATA_W-1]);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg < 3'd4)
            begin
                pp_reg <= a_chunk * b_chunk;
                sh_reg <= 2'(step_reg[0]) + 2'(step_reg[1]);
            end
            if (step_reg >= 3'd1 && step_reg <= 3'd4)
            begin
                acc_reg <= acc_reg + pp_shift;
            end
            if (step_reg == 3'd5)
            begin
                res_reg <= neg_reg ? $signed(tds_pkg::DATA_W'(0) - sat_mag) : $signed(sat_mag);
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ rtl/core/tds_div.sv @@
module tds_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [tds_pkg::DATA_W-1:0]    t,
    input  logic [tds_pkg::DATA_W-1:0]           d,
    output logic                                 done,
    output logic signed [tds_pkg::DATA_W-1:0]    quotient
);

    // numerator is |t| * 2^33: one extra bit for rounding
    localparam int NW    = tds_pkg::DATA_W + 33;
    localparam int QW    = tds_pkg::DATA_W + 1;
    localparam int CNT_W = $clog2(NW + 1);

    logic                         busy_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [NW-1:0]                num_reg;
    logic [tds_pkg::DATA_W-1:0]   r_reg;
    logic [QW-1:0]                q_reg;
    logic [tds_pkg::DATA_W-1:0]   d_reg;
    logic                         neg_reg;
    logic                         done_reg;
    logic signed [tds_pkg::DATA_W-1:0] res_reg;

    logic [tds_pkg::DATA_W:0]     rs;
    logic [tds_pkg::DATA_W:0]     rs_sub;
    logic                         qb;
    logic [QW:0]                  qr;
    logic [QW-1:0]                qm;
    logic [QW-1:0]                lim;
    logic [tds_pkg::DATA_W-1:0]   qs;

    // one restoring step
    always_comb
    begin
        rs     = {r_reg, num_reg[NW-1]};
        rs_sub = rs - {1'b0, d_reg};
        qb     = (rs >= {1'b0, d_reg});
        qr     = {1'b0, q_reg} + (QW+1)'(1);
        qm     = qr[QW:1];
        lim    = neg_reg ? {1'b0, tds_pkg::NEG_LIM} : {1'b0, tds_pkg::POS_LIM};
        qs     = (qm > lim) ? lim[tds_pkg::DATA_W-1:0] : qm[tds_pkg::DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NW))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift in one numerator bit per cycle, then round and sign
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {tds_pkg::mag48(t), 33'b0};
            r_reg   <= '0;
            q_reg   <= '0;
            d_reg   <= d;
            neg_reg <= t[tds_pkg::DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg < CNT_W'(NW))
            begin
                num_reg <= num_reg << 1;
                q_reg   <= {q_reg[QW-2:0], qb};
                r_reg   <= qb ? rs_sub[tds_pkg::DATA_W-1:0] : rs[tds_pkg::DATA_W-1:0];
            end
            else
            begin
                res_reg <= neg_reg ? $signed(tds_pkg::DATA_W'(0) - qs) : $signed(qs);
            end
        end
    end

    assign done     = done_reg;
    assign quotient = res_reg;

endmodule

@@ rtl/core/tridiagonal_sor_solver.sv @@
// Load: one rhs element accepted per cycle; the element with tlast starts the solve.
// Solve: a row takes three read states, four shared multiplies (three at an end row, two
// for a single element), the serial divider and the write-back and accumulate states; a
// check state closes each sweep.
// Output: each element is read from memory, captured, then held valid until taken; then the next.
// Reset (rst_n low, asynchronous) clears control, counters and loads the default
// configuration; the rhs and solution memories are not cleared.
module tridiagonal_sor_solver (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [47:0]                    s_axis_tdata,  // [47:0] rhs_value
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [47:0]                    m_axis_tdata,  // [47:0] solution_value
    output logic                           m_axis_tlast,
    output logic [16:0]                    m_axis_tuser,  // [0] converged, [16:1] sweep_count
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tds_pkg::CIDX_W-1:0]     cfg_index,
    input  logic [tds_pkg::CFG_W-1:0]      cfg_data
);

    localparam int DW = tds_pkg::DATA_W;
    localparam int IW = tds_pkg::IDX_W;
    localparam int CW = tds_pkg::CNT_W;
    localparam int SW = tds_pkg::SWP_W;

    tds_pkg::state_t state_reg;
    tds_pkg::state_t state_next;

    // configuration
    logic [46:0]  alpha_reg;
    logic [32:0]  omega_reg;
    logic [46:0]  tol_reg;
    logic [SW-1:0] maxsw_reg;

    // control
    logic [CW-1:0] count_reg;
    logic [CW-1:0] n_reg;
    logic [IW-1:0] j_reg;
    logic [IW-1:0] k_reg;
    logic          first_reg;
    logic [SW-1:0] sweep_reg;
    logic [SW-1:0] limit_reg;
    logic [63:0]   sum_reg;
    logic [63:0]   bound_reg;
    logic          conv_reg;
    logic          out_valid_reg;

    // datapath
    logic signed [DW-1:0] t_reg;
    logic signed [DW-1:0] old_reg;
    logic signed [DW-1:0] xnext_reg;
    logic signed [DW-1:0] xprev_reg;
    logic signed [DW-1:0] q_reg;
    logic signed [DW-1:0] m1_reg;
    logic signed [DW-1:0] nx_reg;
    logic [63:0]          sq_reg;
    logic [DW-1:0]        out_data_reg;
    logic                 out_last_reg;

    logic                 in_accept;
    logic                 room;
    logic [CW-1:0]        count_inc;
    logic                 has_next;
    logic                 stop;
    logic [SW-1:0]        sweep_inc;

    logic                 rhs_we;
    logic [DW-1:0]        rhs_rdata;
    logic                 sol_we;
    logic [IW-1:0]        sol_raddr;
    logic [DW-1:0]        sol_rdata;

    logic                 mul_start;
    logic signed [DW-1:0] mul_a;
    logic signed [DW-1:0] mul_b;
    logic                 mul_done;
    logic signed [DW-1:0] mul_res;
    logic                 div_start;
    logic                 div_done;
    logic signed [DW-1:0] div_res;

    logic [DW-1:0]        diag;
    logic signed [DW-1:0] off;
    logic signed [DW-1:0] w;
    logic signed [DW-1:0] omw;
    logic signed [DW:0]   diff;
    logic [DW:0]          dmag;
    logic [63:0]          sq_calc;
    logic [63:0]          bound_calc;
    logic [64:0]          sum_add;

    // derived coefficients and small arithmetic
    always_comb
    begin
        diag       = tds_pkg::Q_ONE + {1'b0, alpha_reg};
        off        = $signed({2'b00, alpha_reg[46:1]});
        w          = $signed({15'b0, omega_reg});
        omw        = $signed(tds_pkg::Q_ONE - {15'b0, omega_reg});
        diff       = {nx_reg[DW-1], nx_reg} - {old_reg[DW-1], old_reg};
        dmag       = diff[DW] ? ((DW+1)'(0) - diff) : diff;
        sq_calc    = (dmag[DW:32] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF
                                         : dmag[31:0] * dmag[31:0];
        bound_calc = (tol_reg[46:32] != '0) ? 64'hFFFF_FFFF_FFFF_FFFF
                                            : tol_reg[31:0] * tol_reg[31:0];
        sum_add    = {1'b0, sum_reg} + {1'b0, sq_reg};
        room       = (count_reg < CW'(tds_pkg::MAX_SIZE));
        count_inc  = count_reg + CW'(room);
        has_next   = (({1'b0, j_reg} + CW'(1)) < n_reg);
        sweep_inc  = sweep_reg + SW'(1);
        stop       = (sum_reg <= bound_reg) || (sweep_inc >= limit_reg);
    end

    assign s_axis_tready = (state_reg == tds_pkg::ST_LOAD);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign rhs_we        = in_accept && room;
    assign sol_we        = (state_reg == tds_pkg::ST_WR);
    assign cfg_ready     = 1'b1;

    // pick the memory read address for the current step
    always_comb
    begin
        case (state_reg)
            tds_pkg::ST_RD1: sol_raddr = j_reg + IW'(1);
            tds_pkg::ST_ORD: sol_raddr = k_reg;
            default:         sol_raddr = j_reg;
        endcase
    end

    // steer the shared multiplier
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = off;
        mul_b     = xprev_reg;
        case (state_reg)
            tds_pkg::ST_MA:
            begin
                mul_start = 1'b1;
            end
            tds_pkg::ST_MB:
            begin
                mul_start = 1'b1;
                mul_b     = xnext_reg;
            end
            tds_pkg::ST_MC:
            begin
                mul_start = 1'b1;
                mul_a     = omw;
                mul_b     = old_reg;
            end
            tds_pkg::ST_MD:
            begin
                mul_start = 1'b1;
                mul_a     = w;
                mul_b     = q_reg;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign div_start = (state_reg == tds_pkg::ST_DG);

    tds_ram #(.WIDTH(DW), .DEPTH(tds_pkg::MAX_SIZE)) u_rhs_ram (
        .clk   (clk),
        .we    (rhs_we),
        .waddr (count_reg[IW-1:0]),
        .wdata (s_axis_tdata),
        .raddr (j_reg),
        .rdata (rhs_rdata)
    );

    tds_ram #(.WIDTH(DW), .DEPTH(tds_pkg::MAX_SIZE)) u_sol_ram (
        .clk   (clk),
        .we    (sol_we),
        .waddr (j_reg),
        .wdata (nx_reg),
        .raddr (sol_raddr),
        .rdata (sol_rdata)
    );

    tds_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    tds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .t        (t_reg),
        .d        (diag),
        .done     (div_done),
        .quotient (div_res)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tds_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequence the row updates, sweeps and output
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tds_pkg::ST_LOAD:  if (in_accept && s_axis_tlast) state_next = tds_pkg::ST_RD0;
            tds_pkg::ST_RD0:   state_next = tds_pkg::ST_RD1;
            tds_pkg::ST_RD1:   state_next = tds_pkg::ST_RD2;
            tds_pkg::ST_RD2:
            begin
                if (j_reg != '0)
                begin
                    state_next = tds_pkg::ST_MA;
                end
                else if (has_next)
                begin
                    state_next = tds_pkg::ST_MB;
                end
                else
                begin
                    state_next = tds_pkg::ST_DG;
                end
            end
            tds_pkg::ST_MA:    state_next = tds_pkg::ST_WA;
            tds_pkg::ST_WA:
            begin
                if (mul_done)
                begin
                    state_next = has_next ? tds_pkg::ST_MB : tds_pkg::ST_DG;
                end
            end
            tds_pkg::ST_MB:    state_next = tds_pkg::ST_WB;
            tds_pkg::ST_WB:    if (mul_done) state_next = tds_pkg::ST_DG;
            tds_pkg::ST_DG:    state_next = tds_pkg::ST_WD;
            tds_pkg::ST_WD:    if (div_done) state_next = tds_pkg::ST_MC;
            tds_pkg::ST_MC:    state_next = tds_pkg::ST_WC;
            tds_pkg::ST_WC:    if (mul_done) state_next = tds_pkg::ST_MD;
            tds_pkg::ST_MD:    state_next = tds_pkg::ST_WM;
            tds_pkg::ST_WM:    if (mul_done) state_next = tds_pkg::ST_WR;
            tds_pkg::ST_WR:    state_next = tds_pkg::ST_ACC;
            tds_pkg::ST_ACC:   state_next = has_next ? tds_pkg::ST_RD0 : tds_pkg::ST_CHK;
            tds_pkg::ST_CHK:   state_next = stop ? tds_pkg::ST_ORD : tds_pkg::ST_RD0;
            tds_pkg::ST_ORD:   state_next = tds_pkg::ST_OCAP;
            tds_pkg::ST_OCAP:  state_next = tds_pkg::ST_OSEND;
            tds_pkg::ST_OSEND:
            begin
                if (m_axis_tready)
                begin
                    if (({1'b0, k_reg} + CW'(1)) == n_reg)
                    begin
                        state_next = tds_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = tds_pkg::ST_ORD;
                    end
                end
            end
            default:           state_next = tds_pkg::ST_LOAD;
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 47'd4294967296;
            omega_reg <= 33'd5153960755;
            tol_reg   <= 47'd4295;
            maxsw_reg <= 16'd4096;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tds_pkg::CFG_ALPHA:     alpha_reg <= cfg_data;
                tds_pkg::CFG_OMEGA:     omega_reg <= cfg_data[32:0];
                tds_pkg::CFG_TOLERANCE: tol_reg   <= cfg_data;
                tds_pkg::CFG_MAX_SWEEP: maxsw_reg <= cfg_data[SW-1:0];
                default:                alpha_reg <= alpha_reg;
            endcase
        end
    end

    // control counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            n_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            first_reg     <= 1'b0;
            sweep_reg     <= '0;
            limit_reg     <= '0;
            sum_reg       <= '0;
            bound_reg     <= '0;
            conv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                tds_pkg::ST_LOAD:
                begin
                    if (in_accept)
                    begin
                        count_reg <= count_inc;
                        if (s_axis_tlast)
                        begin
                            n_reg     <= count_inc;
                            count_reg <= '0;
                            j_reg     <= '0;
                            first_reg <= 1'b1;
                            sweep_reg <= '0;
                            sum_reg   <= '0;
                            bound_reg <= bound_calc;
                            limit_reg <= (maxsw_reg == '0) ? SW'(1) : maxsw_reg;
                        end
                    end
                end
                tds_pkg::ST_ACC:
                begin
                    sum_reg <= sum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_add[63:0];
                    if (has_next)
                    begin
                        j_reg <= j_reg + IW'(1);
                    end
                end
                tds_pkg::ST_CHK:
                begin
                    sweep_reg <= sweep_inc;
                    if (stop)
                    begin
                        conv_reg <= (sum_reg <= bound_reg);
                        k_reg    <= '0;
                    end
                    else
                    begin
                        j_reg     <= '0;
                        first_reg <= 1'b0;
                        sum_reg   <= '0;
                    end
                end
                tds_pkg::ST_OCAP:
                begin
                    out_valid_reg <= 1'b1;
                end
                tds_pkg::ST_OSEND:
                begin
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        k_reg         <= k_reg + IW'(1);
                    end
                end
                default:
                begin
                    out_valid_reg <= out_valid_reg;
                end
            endcase
        end
    end

    // row datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tds_pkg::ST_RD1:
            begin
                old_reg <= first_reg ? '0 : $signed(sol_rdata);
                t_reg   <= $signed(rhs_rdata);
            end
            tds_pkg::ST_RD2:
            begin
                xnext_reg <= (first_reg || !has_next) ? '0 : $signed(sol_rdata);
            end
            tds_pkg::ST_WA, tds_pkg::ST_WB:
            begin
                if (mul_done)
                begin
                    t_reg <= tds_pkg::sat48({{2{t_reg[DW-1]}}, t_reg}
                                            + {{2{mul_res[DW-1]}}, mul_res});
                end
            end
            tds_pkg::ST_WD:
            begin
                if (div_done)
                begin
                    q_reg <= div_res;
                end
            end
            tds_pkg::ST_WC:
            begin
                if (mul_done)
                begin
                    m1_reg <= mul_res;
                end
            end
            tds_pkg::ST_WM:
            begin
                if (mul_done)
                begin
                    nx_reg <= tds_pkg::sat48({{2{m1_reg[DW-1]}}, m1_reg}
                                             + {{2{mul_res[DW-1]}}, mul_res});
                end
            end
            tds_pkg::ST_WR:
            begin
                sq_reg    <= sq_calc;
                xprev_reg <= nx_reg;
            end
            tds_pkg::ST_OCAP:
            begin
                out_data_reg <= sol_rdata;
                out_last_reg <= (({1'b0, k_reg} + CW'(1)) == n_reg);
            end
            default:
            begin
                sq_reg <= sq_reg;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {sweep_reg, conv_reg};

endmodule
